// ===== sv/imgmg_pkg.sv =====
`timescale 1ns / 1ps

package imgmg_pkg;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  // Read-back modes
  localparam logic [1:0] MODE_VFLIP = 2'd0;
  localparam logic [1:0] MODE_HFLIP = 2'd1;
  localparam logic [1:0] MODE_GRAY  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  // Divide by three for sums below 2048: (x * 683) >> 11
  localparam int unsigned DIV3_MUL   = 683;
  localparam int unsigned DIV3_SHIFT = 11;

  // Reset values of the size registers
  localparam logic [6:0] SIZE_RESET = 7'd64;

endpackage

// ===== sv/image_mirror_and_gray_top.sv =====
`timescale 1ns / 1ps

// Frame store with mirrored and grayscale read-back.
//
// in_*  : input beats. in_tuser is the command (0 load, 1 emit), in_tdata carries
//         red, green, blue of a loaded pixel. Loads fill the store in raster order.
// out_* : one result beat per emit. tdata holds red, green, blue, tlast marks the
//         final pixel of the frame, tuser is the status (1 = frame not yet loaded,
//         data and tlast are then zero).
// cfg_* : register writes (0 mode, 1 frame width, 2 frame height), taken at once;
//         write only while the block is idle.
//
// Sequencing: loads are taken back to back while the sequencer is idle. An emit
// passes through address compute, store read and output formatting because the
// single frame store is read once per emit and the sequencer handles one emit at
// a time; the input is not ready again until the emit leaves the output step. An
// emit on an incomplete frame skips the store read.
// The output register decouples the sides: loads keep flowing while a result
// waits; a further emit waits in its output step until the receiver takes the
// pending beat. Reset clears the load and read positions, the frame-ready flag
// and the registers; the store contents stay undefined until loaded.

module image_mirror_and_gray_top #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] in_red, [15:8] in_green, [23:16] in_blue
  input  logic        in_tuser,   // [0] cmd

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  output logic        out_tlast,  // last_pixel
  output logic        out_tuser,  // [0] status

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [6:0]  cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WSW   = $clog2(MAX_WIDTH + 1);
  localparam int HSW   = $clog2(MAX_HEIGHT + 1);

  // Configuration registers
  logic [1:0] mode_r;
  logic [6:0] width_r;
  logic [6:0] height_r;

  // Control state
  imgmg_pkg::state_t state_r, state_nxt;
  logic [PW-1:0] lp_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic          ready_r;

  // Emit pipeline
  logic [AW-1:0] addr_r;
  logic          last_r;
  logic          nrdy_r;
  logic [23:0]   rd_r;

  // Output register
  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic        out_last_r;
  logic        out_user_r;

  logic [23:0] mem [DEPTH];

  logic [WSW-1:0] w_c;
  logic [HSW-1:0] h_c;
  logic [31:0]    total;

  logic in_acc, out_acc, is_load, is_emit;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == imgmg_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_valid_r && out_tready;
  assign is_load = in_acc && (in_tuser == imgmg_pkg::CMD_LOAD);
  assign is_emit = in_acc && (in_tuser == imgmg_pkg::CMD_EMIT);

  // Clamp sizes to 1..MAX
  always_comb begin
    if (width_r == 7'd0) w_c = WSW'(1);
    else if (32'(width_r) > 32'(MAX_WIDTH)) w_c = WSW'(MAX_WIDTH);
    else w_c = WSW'(width_r);
    if (height_r == 7'd0) h_c = HSW'(1);
    else if (32'(height_r) > 32'(MAX_HEIGHT)) h_c = HSW'(MAX_HEIGHT);
    else h_c = HSW'(height_r);
    total = 32'(w_c) * 32'(h_c);
  end

  // Load position after an optional new-frame restart
  logic [PW-1:0] lpos;
  logic [31:0]   lpos_inc;
  assign lpos     = ready_r ? '0 : lp_r;
  assign lpos_inc = 32'(lpos) + 32'd1;

  // Read position with wrap, source address, last flag, advance
  logic [RW-1:0] rrow, srow, row_adv;
  logic [CW-1:0] rcol, scol, col_adv;
  logic [31:0]   saddr;
  logic          rlast;

  always_comb begin
    if ((32'(row_r) >= 32'(h_c)) || (32'(col_r) >= 32'(w_c))) begin
      rrow = '0;
      rcol = '0;
    end else begin
      rrow = row_r;
      rcol = col_r;
    end
    srow = rrow;
    scol = rcol;
    case (mode_r)
      imgmg_pkg::MODE_VFLIP: srow = RW'(32'(h_c) - 32'd1 - 32'(rrow));
      imgmg_pkg::MODE_HFLIP: scol = CW'(32'(w_c) - 32'd1 - 32'(rcol));
      default: ;
    endcase
    saddr = 32'(srow) * 32'(w_c) + 32'(scol);
    rlast = (32'(rrow) == 32'(h_c) - 32'd1) && (32'(rcol) == 32'(w_c) - 32'd1);
    if (32'(rcol) + 32'd1 < 32'(w_c)) begin
      col_adv = CW'(32'(rcol) + 32'd1);
      row_adv = rrow;
    end else begin
      col_adv = '0;
      row_adv = (32'(rrow) + 32'd1 < 32'(h_c)) ? RW'(32'(rrow) + 32'd1) : '0;
    end
  end

  // Grayscale by multiply with the reciprocal of three
  logic [9:0]  sum;
  logic [19:0] prod;
  logic [7:0]  avg;
  logic [23:0] fmt;
  assign sum  = 10'(rd_r[23:16]) + 10'(rd_r[15:8]) + 10'(rd_r[7:0]);
  assign prod = 20'(sum) * 20'(imgmg_pkg::DIV3_MUL);
  assign avg  = prod[imgmg_pkg::DIV3_SHIFT +: 8];
  always_comb begin
    if (nrdy_r) fmt = '0;
    else if (mode_r == imgmg_pkg::MODE_GRAY) fmt = {avg, avg, avg};
    else fmt = rd_r;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      imgmg_pkg::ST_IDLE: begin
        if (is_emit) state_nxt = ready_r ? imgmg_pkg::ST_READ : imgmg_pkg::ST_OUT;
      end
      imgmg_pkg::ST_READ: state_nxt = imgmg_pkg::ST_OUT;
      imgmg_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) state_nxt = imgmg_pkg::ST_IDLE;
      end
      default: state_nxt = imgmg_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= imgmg_pkg::ST_IDLE;
      mode_r      <= imgmg_pkg::MODE_VFLIP;
      width_r     <= imgmg_pkg::SIZE_RESET;
      height_r    <= imgmg_pkg::SIZE_RESET;
      lp_r        <= '0;
      row_r       <= '0;
      col_r       <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          imgmg_pkg::REG_MODE:   mode_r   <= cfg_data[1:0];
          imgmg_pkg::REG_WIDTH:  width_r  <= cfg_data;
          imgmg_pkg::REG_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (is_load) begin
        lp_r <= PW'(lpos_inc);
        if (lpos_inc >= total) begin
          ready_r <= 1'b1;
          row_r   <= '0;
          col_r   <= '0;
        end else if (ready_r) begin
          ready_r <= 1'b0;
          row_r   <= '0;
          col_r   <= '0;
        end
      end
      if (is_emit && ready_r) begin
        row_r <= row_adv;
        col_r <= col_adv;
      end
      // Drop a taken beat, load a new one in the output step
      if (state_r == imgmg_pkg::ST_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (is_emit) begin
      addr_r <= AW'(saddr);
      last_r <= rlast;
      nrdy_r <= !ready_r;
    end
    if (state_r == imgmg_pkg::ST_OUT && (!out_valid_r || out_tready)) begin
      out_data_r <= fmt;
      out_last_r <= last_r && !nrdy_r;
      out_user_r <= nrdy_r;
    end
  end

  // Frame store: write on load, read in the read step
  always_ff @(posedge clk) begin
    if (is_load && (32'(lpos) < 32'(DEPTH))) begin
      mem[AW'(lpos)] <= in_tdata;
    end
    if (state_r == imgmg_pkg::ST_READ) begin
      rd_r <= mem[addr_r];
    end
  end

  // Checks
  a_emit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    is_emit |=> !in_tready)
    else $error("input still ready after an emit");

  a_load_flows: assert property (@(posedge clk) disable iff (!rst_n)
    is_load |=> in_tready)
    else $error("load stalled the input");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 24'd0 && !out_tlast))
    else $error("not-ready result carries data");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == imgmg_pkg::ST_OUT))
    else $error("result beat without output step");

endmodule

// ===== verif/image_mirror_and_gray_checker.sv =====
`timescale 1ns / 1ps

module image_mirror_and_gray_checker #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] in_red, [15:8] in_green, [23:16] in_blue
  input  logic        in_tuser,   // [0] cmd

  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  input  logic        out_tlast,  // last_pixel
  input  logic        out_tuser,  // [0] status

  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [6:0]  cfg_data,

  output int unsigned mismatch_count,
  output int unsigned results_owed,
  output int unsigned written_depth
);

  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic       status;
    logic       last;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_beat_t;

  // Shadow of the block: frame contents, positions and registers
  logic [23:0]  frame_mem [STORE_DEPTH];
  int unsigned  load_pos;
  int unsigned  row_pos;
  int unsigned  col_pos;
  int unsigned  high_water;
  int unsigned  mismatches;
  bit           frame_full;
  logic [1:0]   rb_mode;
  logic [6:0]   width_reg;
  logic [6:0]   height_reg;
  pixel_beat_t  expected_pixels[$];

  function automatic int unsigned clamp_dim(logic [6:0] v, int unsigned limit);
    if (v == 7'd0) return 1;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  // Write one pixel in raster order; a load after a full frame starts over
  function automatic void store_pixel(logic [23:0] pix);
    int unsigned total;
    total = clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
    if (frame_full) begin
      frame_full = 1'b0;
      load_pos   = 0;
      row_pos    = 0;
      col_pos    = 0;
    end
    if (load_pos < STORE_DEPTH) frame_mem[load_pos] = pix;
    load_pos++;
    if (load_pos > high_water && load_pos <= STORE_DEPTH) high_water = load_pos;
    if (load_pos >= total) begin
      frame_full = 1'b1;
      row_pos    = 0;
      col_pos    = 0;
    end
  endfunction

  // Produce the next read-back pixel and advance the read position
  function automatic pixel_beat_t read_back_pixel();
    int unsigned w;
    int unsigned h;
    int unsigned src_row;
    int unsigned src_col;
    logic [23:0] pix;
    logic [9:0]  sum;
    pixel_beat_t res;
    w   = clamp_dim(width_reg, MAX_WIDTH);
    h   = clamp_dim(height_reg, MAX_HEIGHT);
    res = '0;
    if (!frame_full) begin
      res.status = 1'b1;
      return res;
    end
    if (row_pos >= h || col_pos >= w) begin
      row_pos = 0;
      col_pos = 0;
    end
    src_row = row_pos;
    src_col = col_pos;
    if (rb_mode == imgmg_pkg::MODE_VFLIP) src_row = h - 1 - row_pos;
    else if (rb_mode == imgmg_pkg::MODE_HFLIP) src_col = w - 1 - col_pos;
    pix       = frame_mem[src_row * w + src_col];
    res.red   = pix[7:0];
    res.green = pix[15:8];
    res.blue  = pix[23:16];
    if (rb_mode == imgmg_pkg::MODE_GRAY) begin
      sum       = 10'(res.red) + 10'(res.green) + 10'(res.blue);
      res.red   = 8'(sum / 10'd3);
      res.green = res.red;
      res.blue  = res.red;
    end
    res.last = (row_pos == h - 1) && (col_pos == w - 1);
    if (col_pos + 1 < w) begin
      col_pos++;
    end else begin
      col_pos = 0;
      row_pos = (row_pos + 1 < h) ? row_pos + 1 : 0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_beat_t got;
    pixel_beat_t want;
    if (!rst_n) begin
      foreach (frame_mem[i]) frame_mem[i] = '0;
      load_pos   = 0;
      row_pos    = 0;
      col_pos    = 0;
      high_water = 0;
      mismatches = 0;
      frame_full = 1'b0;
      rb_mode    = imgmg_pkg::MODE_VFLIP;
      width_reg  = imgmg_pkg::SIZE_RESET;
      height_reg = imgmg_pkg::SIZE_RESET;
      expected_pixels.delete();
    end else begin
      // Compare a result beat against the oldest prediction
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tlast, out_tdata[23:16], out_tdata[15:8], out_tdata[7:0]};
        if (expected_pixels.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: result beat with nothing outstanding: status %0d last %0d rgb %02x %02x %02x",
                     $realtime, got.status, got.last, got.red, got.green, got.blue);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("%0t: pixel mismatch: want status %0d last %0d rgb %02x %02x %02x",
                       $realtime, want.status, want.last, want.red, want.green, want.blue);
              $display("%0t:                  got  status %0d last %0d rgb %02x %02x %02x",
                       $realtime, got.status, got.last, got.red, got.green, got.blue);
            end
            mismatches++;
          end
        end
      end

      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          imgmg_pkg::REG_MODE:   rb_mode    = cfg_data[1:0];
          imgmg_pkg::REG_WIDTH:  width_reg  = cfg_data;
          imgmg_pkg::REG_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end

      // Input beats: loads fill the frame, emits queue a prediction
      if (in_tvalid && in_tready) begin
        if (in_tuser == imgmg_pkg::CMD_LOAD) store_pixel(in_tdata);
        else expected_pixels.push_back(read_back_pixel());
      end
    end
    mismatch_count <= mismatches;
    results_owed   <= expected_pixels.size();
    written_depth  <= high_water;
  end

endmodule

// ===== verif/image_mirror_and_gray_top_test.sv =====
`timescale 1ns / 1ps

module image_mirror_and_gray_top_test;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned DIM_MAX      = 64;

  // Codes with no named counterpart in the package
  localparam logic [1:0] MODE_PASS = 2'd3;
  localparam logic [1:0] REG_NONE  = 2'd3;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [7:0] in_red, [15:8] in_green, [23:16] in_blue
  logic        in_tuser   = 1'b0; // [0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  logic        out_tlast;         // last_pixel
  logic        out_tuser;         // [0] status
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_addr   = '0;
  logic [6:0]  cfg_data   = '0;

  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned written_depth;
  int unsigned cycle_count = 0;
  int unsigned frame_total = DIM_MAX * DIM_MAX;
  int unsigned items_sent  = 0;
  bit          quiet       = 1'b0;

  image_mirror_and_gray_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  image_mirror_and_gray_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed),
    .written_depth  (written_depth)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    if (quiet) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic int unsigned clamp_dim(logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return 32'(v);
  endfunction

  function automatic logic [23:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Result side: stall a random number of cycles before each beat
  initial begin
    int unsigned stall;
    forever begin
      stall = draw_gap();
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Offer one input beat after a random gap and hold it until taken
  task automatic send_beat(input logic cmd, input logic [23:0] pix);
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_loads(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_beat(imgmg_pkg::CMD_LOAD, random_pixel());
  endtask

  task automatic send_emits(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_beat(imgmg_pkg::CMD_EMIT, random_pixel());
  endtask

  // Hold off input until every outstanding result has come back
  task automatic wait_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reconfigure while idle; start a new frame if the old contents cannot cover it
  task automatic set_frame(input logic [1:0] m, input logic [6:0] w, input logic [6:0] h);
    settle();
    write_reg(imgmg_pkg::REG_MODE, 7'(m));
    write_reg(imgmg_pkg::REG_WIDTH, w);
    write_reg(imgmg_pkg::REG_HEIGHT, h);
    frame_total = clamp_dim(w) * clamp_dim(h);
    if (frame_total > written_depth) send_beat(imgmg_pkg::CMD_LOAD, random_pixel());
  endtask

  // Mostly whole frames followed by read-back, with some random noise
  task automatic traffic(input int unsigned n);
    int unsigned sent;
    int unsigned k;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 7) begin
        send_loads(frame_total);
        k = $urandom_range(1, 2 * frame_total + 1);
        send_emits(k);
        sent += frame_total + k;
      end else begin
        k = $urandom_range(1, 6);
        for (int unsigned i = 0; i < k; i++) send_beat(1'($urandom_range(0, 1)), random_pixel());
        sent += k;
      end
      if ($urandom_range(0, 19) == 0) wait_results();
    end
    items_sent += sent;
  endtask

  initial begin
    logic [1:0] m;
    logic [6:0] w;
    logic [6:0] h;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: not-ready emit at reset sizes, then a 3x3 frame in every mode
    send_emits(1);
    set_frame(imgmg_pkg::MODE_VFLIP, 7'd3, 7'd3);
    send_beat(imgmg_pkg::CMD_LOAD, 24'hFFFFFF);
    send_beat(imgmg_pkg::CMD_LOAD, 24'h0000FF);
    send_beat(imgmg_pkg::CMD_LOAD, 24'h00FF00);
    send_emits(1);
    send_beat(imgmg_pkg::CMD_LOAD, 24'hFF0000);
    send_beat(imgmg_pkg::CMD_LOAD, 24'h123456);
    send_beat(imgmg_pkg::CMD_LOAD, 24'hFFFFFF);
    send_beat(imgmg_pkg::CMD_LOAD, 24'h010203);
    send_beat(imgmg_pkg::CMD_LOAD, 24'hFEFDFC);
    send_emits(3);
    settle();
    write_reg(imgmg_pkg::REG_MODE, 7'(imgmg_pkg::MODE_HFLIP));
    send_emits(3);
    settle();
    write_reg(imgmg_pkg::REG_MODE, 7'(imgmg_pkg::MODE_GRAY));
    send_emits(3);
    settle();
    write_reg(imgmg_pkg::REG_MODE, 7'(MODE_PASS));
    send_emits(1);
    // Load after a full frame starts over, so the frame is not ready again
    send_beat(imgmg_pkg::CMD_LOAD, 24'h000000);
    send_emits(1);

    // Full-width frame; one pixel is already in and set_frame adds one more
    quiet = 1'b1;
    set_frame(imgmg_pkg::MODE_GRAY, 7'd64, 7'd2);
    send_loads(frame_total - 2);
    send_emits(frame_total + 70);

    // Shrink with the read position beyond the new width
    quiet = 1'b0;
    set_frame(imgmg_pkg::MODE_VFLIP, 7'd5, 7'd3);
    send_emits(3);

    // Shrink in the middle of loading; the next load completes the frame
    set_frame(imgmg_pkg::MODE_HFLIP, 7'd4, 7'd4);
    send_loads(10);
    set_frame(MODE_PASS, 7'd3, 7'd3);
    send_loads(1);
    send_emits(10);
    traffic(60);

    // Unknown register index, zero sizes, oversize sizes
    settle();
    write_reg(REG_NONE, 7'h7F);
    set_frame(imgmg_pkg::MODE_GRAY, 7'd0, 7'd0);
    traffic(30);
    set_frame(imgmg_pkg::MODE_HFLIP, 7'd127, 7'd1);
    traffic(100);
    set_frame(imgmg_pkg::MODE_VFLIP, 7'd1, 7'd100);
    traffic(100);

    // Random phases
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      m = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) begin
        w = 7'($urandom_range(9, 127));
        h = 7'($urandom_range(0, 2));
      end else begin
        w = 7'($urandom_range(1, 8));
        h = 7'($urandom_range(1, 8));
      end
      set_frame(m, w, h);
      traffic($urandom_range(60, 140));
    end

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/imgmg_pkg.sv
sv/image_mirror_and_gray_top.sv
verif/image_mirror_and_gray_checker.sv
verif/image_mirror_and_gray_top_test.sv
